@@ rtl/core/bfsa_pkg.sv @@
// package for the best-fit segment allocator
// types, constants and codes shared by the table memory and the top level
package bfsa_pkg;

	localparam int MaxSegments = 64;
	localparam int AlignBytes  = 32;

	localparam logic [23:0] SMALL_RAM = 24'd2097152;
	localparam logic [23:0] LARGE_RAM = 24'd8388608;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE  = 2'd1;

	localparam logic [2:0] RC_OK        = 3'd0;
	localparam logic [2:0] RC_ZERO      = 3'd1;
	localparam logic [2:0] RC_NOT_READY = 3'd2;
	localparam logic [2:0] RC_NO_FIT    = 3'd3;
	localparam logic [2:0] RC_FULL      = 3'd4;
	localparam logic [2:0] RC_NOT_FOUND = 3'd5;
	localparam logic [2:0] RC_ALREADY   = 3'd6;

	localparam logic [1:0] REG_RAM_LARGE = 2'd0;
	localparam logic [1:0] REG_RESERVE   = 2'd1;
	localparam logic [1:0] REG_ENABLE    = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [23:0] size_bytes;
		logic [22:0] address;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [22:0] alloc_address;
		logic [23:0] largest_hole;
		logic [23:0] hole_bytes;
		logic [23:0] taken_bytes;
		logic [6:0]  hole_count;
		logic [6:0]  taken_count;
		logic        pool_ready;
		logic [23:0] pool_start;
		logic [23:0] pool_bytes;
	} rsp_t;

	// one table entry
	typedef struct packed {
		logic [22:0] start;
		logic [23:0] size;
		logic        used;
	} seg_t;

endpackage

@@ rtl/core/bfsa_seg_ram.sv @@
// segment table memory, one write port and one registered read port
// depends on bfsa_pkg for the entry type
module bfsa_seg_ram import bfsa_pkg::*; #(
	parameter int MAX_SEGMENTS = MaxSegments
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(MAX_SEGMENTS)-1:0] waddr,
	input  seg_t                            wdata,
	input  logic [$clog2(MAX_SEGMENTS)-1:0] raddr,
	output seg_t                            rdata
);

	seg_t mem [MAX_SEGMENTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/best_fit_segment_allocator_top.sv @@
// top level of the best-fit segment allocator: sequencer, config and result register
// depends on bfsa_pkg and bfsa_seg_ram
//
//  channel  | direction | signals                          | payload
//  ---------+-----------+----------------------------------+---------
//  request  | in        | req_valid / req_stall            | req_t
//  response | out       | rsp_valid / rsp_stall            | rsp_t
//  config   | in        | cfg_we, cfg_index, cfg_data      | 24 bits
//
// one request at a time; the table lives in a single-port-read memory with a registered
// read, so every scan reads the entries one at a time
// an operation runs a best-fit or address search pass, a shift pass where entries
// move (one read and one write per moved entry) and a totals pass over the table
// reset clears the count, ready flag and config registers; the table itself is not cleared
// req_stall is high from an accepted transfer until its result is registered;
// a result held by rsp_stall keeps the next operation waiting at its end
module best_fit_segment_allocator_top import bfsa_pkg::*; #(
	parameter int MAX_SEGMENTS = MaxSegments,
	parameter int ALIGN_BYTES  = AlignBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
	localparam logic [24:0] AMASK = 25'(ALIGN_BYTES - 1);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SRCH  = 4'd1;  // scan for best fit or address
	localparam logic [3:0] ST_PICK  = 4'd2;  // read best/found entry
	localparam logic [3:0] ST_EVAL  = 4'd3;  // decide on the entry
	localparam logic [3:0] ST_SHUP  = 4'd4;  // shift entries up (insert)
	localparam logic [3:0] ST_NBR   = 4'd5;  // read neighbours for a free
	localparam logic [3:0] ST_MERGE = 4'd6;
	localparam logic [3:0] ST_SHDN  = 4'd7;  // shift entries down (remove)
	localparam logic [3:0] ST_SUM   = 4'd8;  // totals pass
	localparam logic [3:0] ST_DONE  = 4'd9;
	localparam logic [3:0] ST_WAIT  = 4'd10;
	localparam logic [3:0] ST_NRD   = 4'd11;

	logic [3:0] state_q;

	// config registers
	logic        ram_large_q, pool_enable_q;
	logic [23:0] reserve_q;
	logic        ready_q;
	logic [23:0] base_q, span_q;
	logic [CW-1:0] count_q;

	req_t        req_q;
	logic [23:0] need_q;          // rounded size
	logic [CW-1:0] idx_q;         // scan index
	logic        rd_v_q;          // read data is valid for idx_rd_q
	logic [CW-1:0] idx_rd_q;
	logic        found_q;
	logic [IW-1:0] best_q;
	logic [23:0] fit_size_q;
	seg_t        cur_q;           // chosen entry
	seg_t        prev_q, next_q;
	logic        has_next_q;
	logic [CW-1:0] rm_q;          // entries to remove in the down shift
	logic [CW-1:0] dst_q;         // write address of the merged entry
	logic [2:0]  code_q;
	logic [22:0] grant_q;
	logic [23:0] largest_q, fbytes_q, abytes_q;
	logic [6:0]  fblk_q, ablk_q;
	logic [1:0]  nstep_q;

	// memory port
	logic          we;
	logic [IW-1:0] waddr, raddr;
	seg_t          wdata, rdata;

	bfsa_seg_ram #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// rebuild values from the registers as they will be after a write
	logic        nx_large, nx_en;
	logic [23:0] nx_res, nx_ram;
	logic [24:0] nx_r;
	logic        nx_ok;

	always_comb begin
		nx_large = ram_large_q;
		nx_res   = reserve_q;
		nx_en    = pool_enable_q;
		unique case (cfg_index)
			REG_RAM_LARGE: nx_large = cfg_data[0];
			REG_RESERVE:   nx_res   = cfg_data;
			REG_ENABLE:    nx_en    = cfg_data[0];
			default:       ;
		endcase
		nx_ram = nx_large ? LARGE_RAM : SMALL_RAM;
		nx_r   = ({1'b0, nx_res} + AMASK) / 25'(ALIGN_BYTES) * 25'(ALIGN_BYTES);
		nx_ok  = nx_en && (nx_r < {1'b0, nx_ram});
	end

	logic cfg_hit;
	assign cfg_hit = cfg_we && (cfg_index == REG_RAM_LARGE || cfg_index == REG_RESERVE
		|| cfg_index == REG_ENABLE);

	// rounded request size
	logic [24:0] need_c;
	assign need_c = ({1'b0, req.size_bytes} + AMASK) / 25'(ALIGN_BYTES) * 25'(ALIGN_BYTES);

	logic accept;
	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);

	logic [IW-1:0] idx_rd_i;
	assign idx_rd_i = idx_rd_q[IW-1:0];

	logic [CW-1:0] best_p1;
	assign best_p1 = CW'(best_q) + CW'(1);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = idx_q[IW-1:0];
		if (cfg_we && cfg_hit && state_q == ST_IDLE) begin
			we    = nx_ok;
			waddr = '0;
			wdata = '{start: nx_r[22:0], size: nx_ram - nx_r[23:0], used: 1'b0};
		end
		unique case (state_q)
			ST_PICK: raddr = best_q;
			ST_NBR:  raddr = (nstep_q == 2'd0) ? best_q - IW'(1) : best_q + IW'(1);
			ST_SHUP: if (rd_v_q) begin
				we    = 1'b1;
				waddr = IW'(idx_rd_q + CW'(1));
				wdata = rdata;
			end
			ST_MERGE: begin
				we    = 1'b1;
				waddr = dst_q[IW-1:0];
				wdata = '{start: cur_q.start, size: cur_q.size, used: 1'b0};
			end
			ST_SHDN: if (rd_v_q) begin
				we    = 1'b1;
				waddr = IW'(idx_rd_q - rm_q);
				wdata = rdata;
			end
			default: ;
		endcase
		if (state_q == ST_WAIT) begin
			// write the split pair after the up shift
			we    = 1'b1;
			waddr = (nstep_q == 2'd0) ? best_q : IW'(best_p1);
			wdata = (nstep_q == 2'd0)
				? '{start: cur_q.start, size: need_q, used: 1'b1}
				: '{start: cur_q.start + need_q[22:0], size: cur_q.size - need_q,
					used: 1'b0};
		end
		if (state_q == ST_EVAL && found_q && req_q.func == FUNC_ALLOC
				&& fit_size_q == need_q) begin
			we    = 1'b1;
			waddr = best_q;
			wdata = '{start: rdata.start, size: rdata.size, used: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ram_large_q   <= 1'b0;
			reserve_q     <= '0;
			pool_enable_q <= 1'b0;
			ready_q       <= 1'b0;
			base_q        <= '0;
			span_q        <= '0;
			count_q       <= '0;
			rsp_valid     <= 1'b0;
			rd_v_q        <= 1'b0;
		end else begin
			if (cfg_hit) begin
				ram_large_q   <= nx_large;
				reserve_q     <= nx_res;
				pool_enable_q <= nx_en;
				ready_q       <= nx_ok;
				base_q        <= nx_ok ? nx_r[23:0] : '0;
				span_q        <= nx_ok ? nx_ram - nx_r[23:0] : '0;
				count_q       <= nx_ok ? CW'(1) : '0;
			end
			// a new result in the same cycle is loaded by the done state
			if (rsp_valid && !rsp_stall && state_q != ST_DONE) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (accept) begin
					req_q       <= req;
					need_q      <= need_c[23:0];
					grant_q     <= '0;
					found_q     <= 1'b0;
					idx_q       <= '0;
					rd_v_q      <= 1'b0;
					if (req.func == FUNC_ALLOC) begin
						if (req.size_bytes == '0) begin
							code_q  <= RC_ZERO;
							state_q <= ST_SUM;
						end else if (!ready_q) begin
							code_q  <= RC_NOT_READY;
							state_q <= ST_SUM;
						end else if (req.size_bytes > span_q) begin
							code_q  <= RC_NO_FIT;
							state_q <= ST_SUM;
						end else begin
							code_q  <= RC_OK;
							state_q <= ST_SRCH;
						end
					end else if (req.func == FUNC_FREE && req.address != '0) begin
						if (!ready_q) begin
							code_q  <= RC_NOT_READY;
							state_q <= ST_SUM;
						end else begin
							code_q  <= RC_OK;
							state_q <= ST_SRCH;
						end
					end else begin
						code_q  <= RC_OK;
						state_q <= ST_SUM;
					end
				end
				ST_SRCH: begin
					if (rd_v_q) begin
						if (req_q.func == FUNC_ALLOC) begin
							if (!rdata.used && rdata.size >= need_q
									&& (!found_q || rdata.size < fit_size_q)) begin
								found_q    <= 1'b1;
								best_q     <= idx_rd_i;
								fit_size_q <= rdata.size;
							end
						end else if (!found_q && rdata.start == req_q.address) begin
							found_q <= 1'b1;
							best_q  <= idx_rd_i;
						end
					end
					if (idx_q < count_q) begin
						idx_rd_q <= idx_q;
						rd_v_q   <= 1'b1;
						idx_q    <= idx_q + CW'(1);
					end else begin
						rd_v_q <= 1'b0;
						if (!rd_v_q) state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (!found_q) begin
						code_q  <= (req_q.func == FUNC_ALLOC) ? RC_NO_FIT : RC_NOT_FOUND;
						idx_q   <= '0;
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					cur_q <= rdata;
					if (req_q.func == FUNC_ALLOC) begin
						if (fit_size_q == need_q) begin
							grant_q <= rdata.start;
							idx_q   <= '0;
							state_q <= ST_SUM;
						end else if (count_q >= MAXC) begin
							code_q  <= RC_FULL;
							idx_q   <= '0;
							state_q <= ST_SUM;
						end else begin
							// move entries best+1..count-1 up by one, from the top
							idx_q   <= count_q - CW'(1);
							rd_v_q  <= 1'b0;
							state_q <= ST_SHUP;
						end
					end else if (!rdata.used) begin
						code_q  <= RC_ALREADY;
						idx_q   <= '0;
						state_q <= ST_SUM;
					end else begin
						nstep_q    <= 2'd0;
						has_next_q <= 1'b0;
						state_q    <= ST_NBR;
					end
				end
				ST_SHUP: begin
					if (idx_q > CW'(best_q) && idx_q != '1) begin
						idx_rd_q <= idx_q;
						rd_v_q   <= 1'b1;
						idx_q    <= idx_q - CW'(1);
					end else begin
						rd_v_q <= 1'b0;
						if (!rd_v_q) begin
							nstep_q <= 2'd0;
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (nstep_q == 2'd0) begin
						nstep_q <= 2'd1;
					end else begin
						count_q <= count_q + CW'(1);
						grant_q <= cur_q.start;
						idx_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_NBR: begin
					// step 0 issues prev read, 1 issues next read and takes prev, 2 takes next
					nstep_q <= nstep_q + 2'd1;
					if (nstep_q == 2'd1) begin
						prev_q <= rdata;
					end
					if (nstep_q == 2'd2) begin
						next_q     <= rdata;
						has_next_q <= (best_p1 < count_q);
						state_q    <= ST_MERGE;
					end
					if (nstep_q == 2'd2) begin
						if (best_q != '0 && !prev_q.used) begin
							dst_q       <= CW'(best_q) - CW'(1);
							cur_q.start <= prev_q.start;
							cur_q.size  <= prev_q.size + cur_q.size;
							rm_q        <= CW'(1);
						end else begin
							dst_q <= CW'(best_q);
							rm_q  <= '0;
						end
					end
				end
				ST_MERGE: begin
					// folds in a free successor first, if any, then writes the merged entry
					if (has_next_q && !next_q.used) begin
						cur_q.size <= cur_q.size + next_q.size;
						rm_q       <= rm_q + CW'(1);
						has_next_q <= 1'b0;
						state_q    <= ST_MERGE;
					end else begin
						// first entry that survives above the merged span
						idx_q   <= dst_q + rm_q + CW'(1);
						rd_v_q  <= 1'b0;
						state_q <= (rm_q == '0) ? ST_NRD : ST_SHDN;
					end
				end
				ST_SHDN: begin
					if (idx_q < count_q) begin
						idx_rd_q <= idx_q;
						rd_v_q   <= 1'b1;
						idx_q    <= idx_q + CW'(1);
					end else begin
						rd_v_q <= 1'b0;
						if (!rd_v_q) begin
							count_q <= count_q - rm_q;
							idx_q   <= '0;
							state_q <= ST_SUM;
						end
					end
				end
				ST_NRD: begin
					idx_q   <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (!rd_v_q && idx_q == '0) begin
						largest_q <= '0;
						fbytes_q  <= '0;
						abytes_q  <= '0;
						fblk_q    <= '0;
						ablk_q    <= '0;
					end
					if (rd_v_q) begin
						if (rdata.used) begin
							abytes_q <= abytes_q + rdata.size;
							ablk_q   <= ablk_q + 7'd1;
						end else begin
							fbytes_q <= fbytes_q + rdata.size;
							fblk_q   <= fblk_q + 7'd1;
							if (rdata.size > largest_q) largest_q <= rdata.size;
						end
					end
					if (idx_q < count_q) begin
						rd_v_q <= 1'b1;
						idx_q  <= idx_q + CW'(1);
					end else begin
						rd_v_q <= 1'b0;
						if (!rd_v_q || idx_q == count_q) state_q <= rd_v_q ? ST_SUM : ST_DONE;
						if (rd_v_q) idx_q <= count_q + CW'(0);
					end
				end
				ST_DONE: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp.result_code   <= code_q;
						rsp.alloc_address <= grant_q;
						rsp.largest_hole  <= largest_q;
						rsp.hole_bytes    <= fbytes_q;
						rsp.taken_bytes   <= abytes_q;
						rsp.hole_count    <= fblk_q;
						rsp.taken_count   <= ablk_q;
						rsp.pool_ready    <= ready_q;
						rsp.pool_start    <= base_q;
						rsp.pool_bytes    <= span_q;
						rsp_valid         <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ verif/testbench.sv @@
// testbench for best_fit_segment_allocator_top: directed and random request streams
// checked against a behavioral model of the segment table kept here; needs bfsa_pkg
module testbench;
	import bfsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TableDepth = 64;
	localparam int Granule    = 32;

	// func codes not named in the package
	localparam logic [1:0] FUNC_QUERY = 2'd2;
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	best_fit_segment_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock: 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// shadow of the allocator: segment table and configuration
	logic [22:0] tbl_start [TableDepth];
	logic [23:0] tbl_size  [TableDepth];
	logic        tbl_used  [TableDepth];
	int unsigned tbl_count;
	logic        shadow_ready;
	logic        cfg_large;
	logic [23:0] cfg_reserve;
	logic        cfg_enable;
	int unsigned shadow_base;
	int unsigned shadow_span;

	rsp_t        expected_rsp_q[$];
	int unsigned live_addr_q[$];
	int          errors;

	// response-side stall control
	int          hold_request;
	int          hold_left;
	int          stall_left;
	bit          quiet_sender;

	function automatic int unsigned round_granule(int unsigned v);
		return ((v + Granule - 1) / Granule) * Granule;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function void rebuild_pool();
		int unsigned ram;
		int unsigned r;
		ram = cfg_large ? 32'(LARGE_RAM) : 32'(SMALL_RAM);
		r = round_granule(cfg_reserve);
		tbl_count = 0;
		shadow_ready = 1'b0;
		shadow_base = 0;
		shadow_span = 0;
		live_addr_q.delete();
		if (!cfg_enable || r >= ram)
			return;
		tbl_start[0] = r[22:0];
		tbl_size[0] = 24'(ram - r);
		tbl_used[0] = 1'b0;
		tbl_count = 1;
		shadow_ready = 1'b1;
		shadow_base = r;
		shadow_span = ram - r;
	endfunction

	function void drop_entry(int unsigned i);
		for (int unsigned k = i; k + 1 < tbl_count; k++) begin
			tbl_start[k] = tbl_start[k + 1];
			tbl_size[k] = tbl_size[k + 1];
			tbl_used[k] = tbl_used[k + 1];
		end
		tbl_count--;
	endfunction

	function logic [2:0] grant_segment(int unsigned want, output int unsigned granted);
		int unsigned best;
		int unsigned fit_size;
		bit found;
		granted = 0;
		best = 0;
		fit_size = 0;
		found = 0;
		if (want == 0)
			return RC_ZERO;
		if (!shadow_ready)
			return RC_NOT_READY;
		if (want > shadow_span)
			return RC_NO_FIT;
		want = round_granule(want);
		for (int unsigned i = 0; i < tbl_count; i++)
			if (!tbl_used[i] && tbl_size[i] >= want && (!found || tbl_size[i] < fit_size)) begin
				found = 1;
				best = i;
				fit_size = tbl_size[i];
			end
		if (!found)
			return RC_NO_FIT;
		if (fit_size != want) begin
			if (tbl_count >= TableDepth)
				return RC_FULL;
			for (int unsigned k = tbl_count; k > best + 1; k--) begin
				tbl_start[k] = tbl_start[k - 1];
				tbl_size[k] = tbl_size[k - 1];
				tbl_used[k] = tbl_used[k - 1];
			end
			tbl_start[best + 1] = 23'(tbl_start[best] + want);
			tbl_size[best + 1] = 24'(fit_size - want);
			tbl_used[best + 1] = 1'b0;
			tbl_count++;
			tbl_size[best] = 24'(want);
		end
		tbl_used[best] = 1'b1;
		granted = tbl_start[best];
		return RC_OK;
	endfunction

	function logic [2:0] release_segment(int unsigned addr);
		int unsigned i;
		if (addr == 0)
			return RC_OK;
		if (!shadow_ready)
			return RC_NOT_READY;
		for (i = 0; i < tbl_count; i++)
			if (tbl_start[i] == addr)
				break;
		if (i >= tbl_count)
			return RC_NOT_FOUND;
		if (!tbl_used[i])
			return RC_ALREADY;
		tbl_used[i] = 1'b0;
		if (i > 0 && !tbl_used[i - 1]) begin
			tbl_size[i - 1] += tbl_size[i];
			drop_entry(i);
			i--;
		end
		if (i + 1 < tbl_count && !tbl_used[i + 1]) begin
			tbl_size[i] += tbl_size[i + 1];
			drop_entry(i + 1);
		end
		return RC_OK;
	endfunction

	// expected response for one request; updates the shadow table
	function rsp_t predict_allocation(req_t r);
		rsp_t e;
		int unsigned granted;
		int unsigned largest, fbytes, abytes, fblk, ablk;
		granted = 0;
		e = '0;
		e.result_code = RC_OK;
		if (r.func == FUNC_ALLOC) begin
			e.result_code = grant_segment(r.size_bytes, granted);
			if (e.result_code != RC_OK)
				granted = 0;
			else
				live_addr_q.push_back(granted);
		end else if (r.func == FUNC_FREE) begin
			e.result_code = release_segment(r.address);
			if (e.result_code == RC_OK && r.address != 0)
				foreach (live_addr_q[j])
					if (live_addr_q[j] == r.address) begin
						live_addr_q.delete(j);
						break;
					end
		end
		largest = 0;
		fbytes = 0;
		abytes = 0;
		fblk = 0;
		ablk = 0;
		for (int unsigned i = 0; i < tbl_count; i++)
			if (tbl_used[i]) begin
				abytes += tbl_size[i];
				ablk++;
			end else begin
				fbytes += tbl_size[i];
				fblk++;
				if (tbl_size[i] > largest)
					largest = tbl_size[i];
			end
		e.alloc_address = granted[22:0];
		e.largest_hole = largest[23:0];
		e.hole_bytes = fbytes[23:0];
		e.taken_bytes = abytes[23:0];
		e.hole_count = fblk[6:0];
		e.taken_count = ablk[6:0];
		e.pool_ready = shadow_ready;
		e.pool_start = shadow_base[23:0];
		e.pool_bytes = shadow_span[23:0];
		return e;
	endfunction

	task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v !== got_v) begin
			$display("%0t ns: mismatch in %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// response checker: sample at rising edge on each transfer
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t ns: response with nothing expected, actual %h", $time, rsp);
				errors++;
			end else begin
				e = expected_rsp_q.pop_front();
				check_field("result_code", e.result_code, rsp.result_code);
				check_field("alloc_address", e.alloc_address, rsp.alloc_address);
				check_field("largest_hole", e.largest_hole, rsp.largest_hole);
				check_field("hole_bytes", e.hole_bytes, rsp.hole_bytes);
				check_field("taken_bytes", e.taken_bytes, rsp.taken_bytes);
				check_field("hole_count", e.hole_count, rsp.hole_count);
				check_field("taken_count", e.taken_count, rsp.taken_count);
				check_field("pool_ready", e.pool_ready, rsp.pool_ready);
				check_field("pool_start", e.pool_start, rsp.pool_start);
				check_field("pool_bytes", e.pool_bytes, rsp.pool_bytes);
			end
		end
	end

	// receiver stall: random gaps, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
			stall_left = quiet_sender ? 0 : pick_gap();
		end
	end

	// one request transfer; entered and left just after a falling edge
	task automatic send_request(logic [1:0] func, int unsigned size, int unsigned addr);
		req_t item;
		int gap;
		item.func = func;
		item.size_bytes = size[23:0];
		item.address = addr[22:0];
		gap = quiet_sender ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		expected_rsp_q.push_back(predict_allocation(item));
		@(negedge clk);
	endtask

	// register write only when the block is idle
	task automatic write_register(logic [1:0] idx, int unsigned value);
		req_valid <= 1'b0;
		wait (expected_rsp_q.size() == 0);
		repeat (250) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[23:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RAM_LARGE)
			cfg_large = value[0];
		else if (idx == REG_RESERVE)
			cfg_reserve = value[23:0];
		else
			cfg_enable = value[0];
		rebuild_pool();
	endtask

	// not-ready behavior, pool extremes and each error code but RC_FULL
	task automatic test_directed();
		send_request(FUNC_QUERY, 0, 0);
		send_request(FUNC_ALLOC, 100, 0);
		send_request(FUNC_FREE, 0, 64);
		send_request(FUNC_FREE, 0, 0);
		send_request(FUNC_ALLOC, 0, 0);
		write_register(REG_ENABLE, 1);
		send_request(FUNC_QUERY, 24'hFFFFFF, 23'h7FFFFF);
		send_request(FUNC_ALLOC, 1, 0);
		send_request(FUNC_ALLOC, 33, 0);
		send_request(FUNC_ALLOC, 24'hFFFFFF, 0);
		send_request(FUNC_ALLOC, 2097152, 0);
		send_request(FUNC_FREE, 0, 23'h7FFFFF);
		send_request(FUNC_FREE, 0, 32);
		send_request(FUNC_FREE, 0, 32);
		send_request(FUNC_FREE, 0, 0);
		send_request(FUNC_SPARE, 5, 5);
		send_request(FUNC_ALLOC, 0, 0);
		// reserve at the very end of the small memory: no room
		write_register(REG_RESERVE, 2097121);
		send_request(FUNC_ALLOC, 32, 0);
		write_register(REG_RAM_LARGE, 1);
		send_request(FUNC_ALLOC, 8388608 - 2097152, 0);
		write_register(REG_RESERVE, 8388608);
		send_request(FUNC_QUERY, 0, 0);
		write_register(REG_RESERVE, 8388576);
		send_request(FUNC_ALLOC, 32, 0);
		write_register(REG_RESERVE, 0);
		send_request(FUNC_ALLOC, 8388608, 0);
		send_request(FUNC_FREE, 0, 0);
		write_register(REG_ENABLE, 0);
		send_request(FUNC_FREE, 0, 4096);
	endtask

	// fill the segment table, hit the full case, then unwind with merges
	task automatic test_table_full();
		int unsigned held[$];
		write_register(REG_RAM_LARGE, 0);
		write_register(REG_ENABLE, 1);
		for (int i = 0; i < TableDepth - 1; i++)
			send_request(FUNC_ALLOC, $urandom_range(1, 64), 0);
		send_request(FUNC_ALLOC, 32, 0);
		send_request(FUNC_ALLOC, shadow_span, 0);
		send_request(FUNC_QUERY, 0, 0);
		held = live_addr_q;
		foreach (held[i])
			if (i % 2 == 0)
				send_request(FUNC_FREE, 0, held[i]);
		foreach (held[i])
			if (i % 2 == 1)
				send_request(FUNC_FREE, 0, held[i]);
	endtask

	// mostly well-formed alloc/free traffic, plus noise
	task automatic test_random_traffic(int count, bit with_holdoff);
		int pick;
		int unsigned sz;
		for (int n = 0; n < count; n++) begin
			if (with_holdoff && n == count / 2)
				hold_request = 600;
			quiet_sender = (n % 200) < 30;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if ($urandom_range(0, 9) < 7)
					sz = $urandom_range(1, 4096);
				else if ($urandom_range(0, 3) != 0)
					sz = $urandom_range(1, 400000);
				else
					sz = $urandom_range(0, 24'hFFFFFF);
				send_request(FUNC_ALLOC, sz, $urandom_range(0, 23'h7FFFFF));
			end else if (pick < 80 && live_addr_q.size() > 0)
				send_request(FUNC_FREE, $urandom_range(0, 24'hFFFFFF),
					live_addr_q[$urandom_range(0, live_addr_q.size() - 1)]);
			else if (pick < 86)
				send_request(FUNC_FREE, 0, $urandom_range(0, 23'h7FFFFF));
			else if (pick < 90)
				send_request(FUNC_FREE, 0, shadow_base + 32 * $urandom_range(0, 64));
			else if (pick < 95)
				send_request($urandom_range(0, 1) ? FUNC_QUERY : FUNC_SPARE,
					$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 23'h7FFFFF));
			else
				send_request(FUNC_ALLOC, 0, 0);
		end
		quiet_sender = 0;
	endtask

	// the run under several pool settings
	task automatic test_pool_settings();
		write_register(REG_RESERVE, $urandom_range(1, 8192));
		test_random_traffic(350, 1);
		write_register(REG_RAM_LARGE, 1);
		write_register(REG_RESERVE, $urandom_range(0, 24'hFFFFFF) & 24'h7FFFFF);
		test_random_traffic(300, 0);
		write_register(REG_RESERVE, 8388608 - 32 * $urandom_range(300, 3000));
		test_random_traffic(200, 0);
		write_register(REG_RAM_LARGE, 0);
		write_register(REG_RESERVE, 2097152 - 32 * $urandom_range(100, 400));
		test_random_traffic(150, 0);
	endtask

	initial begin
		errors = 0;
		hold_request = 0;
		hold_left = 0;
		stall_left = 0;
		quiet_sender = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RAM_LARGE;
		cfg_data = '0;
		cfg_large = 1'b0;
		cfg_reserve = '0;
		cfg_enable = 1'b0;
		rebuild_pool();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_table_full();
		test_pool_settings();
		req_valid <= 1'b0;
		wait (expected_rsp_q.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("best_fit_segment_allocator_top test passed");
		else
			$display("best_fit_segment_allocator_top test failed");
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#60ms;
		$display("best_fit_segment_allocator_top test failed");
		$finish;
	end

endmodule

@@ best_fit_segment_allocator_top.f @@
rtl/core/bfsa_pkg.sv
rtl/core/bfsa_seg_ram.sv
rtl/core/best_fit_segment_allocator_top.sv
verif/testbench.sv
